FILE: sv/sgrb_pkg.sv
// ----------------------------------------------------------------------------
// sgrb_pkg - shared types and constants of the sensor gateway
// frame type codes, result kinds, register indexes and item layouts
// ----------------------------------------------------------------------------
package sgrb_pkg;

    // frame type byte
    localparam logic [7:0] FT_DISCOVER  = 8'h01;
    localparam logic [7:0] FT_REGISTER  = 8'h03;
    localparam logic [7:0] FT_DATA      = 8'h05;
    localparam logic [7:0] DATA_MIN_LEN = 8'd7;

    // input item kind
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] RK_OFFER  = 2'd0;
    localparam logic [1:0] RK_ACK    = 2'd1;
    localparam logic [1:0] RK_RECORD = 2'd2;

    // configuration register indexes
    localparam logic REG_DEFAULT_IVL  = 1'b0;
    localparam logic REG_FLUSH_PERIOD = 1'b1;

    localparam logic [15:0] DEFAULT_IVL_RST  = 16'd300;
    localparam logic [15:0] FLUSH_PERIOD_RST = 16'd600;
    localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

    // input item payload, last declared field in the lowest bits
    typedef struct packed {
        logic [15:0] batt_mv;
        logic [31:0] weight_bits;
        logic [7:0]  frame_len;
        logic [7:0]  pkt_type;
        logic [47:0] sender_addr;
    } t_frame_data;

    // result item payload, last declared field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [5:0]  batch_count;
        logic [15:0] record_battery;
        logic [31:0] record_weight;
        logic [5:0]  scale_index;
        logic [15:0] ack_ivl;
        logic [47:0] dest_addr;
    } t_result_data;

    typedef struct packed {
        logic       end_of_batch;
        logic [1:0] result_kind;
    } t_result_user;

endpackage

FILE: sv/sensor_gateway_register_and_batch.sv
// ----------------------------------------------------------------------------
// sensor_gateway_register_and_batch - sensor registration and reading batches
// answers discover and register frames, batches data readings, flushes on ticks
// ----------------------------------------------------------------------------
// usage
//   slave stream: one item is a received frame (tuser = 0) or a one-second
//     tick (tuser = 1); tick items ignore tdata
//   master stream: offers, acks and batch records; tlast marks the final
//     result caused by one input item, tuser carries the result kind and the
//     end-of-batch flag
//   config port: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//     (0 default interval, 1 flush period); the user writes only while the
//     block is idle, and the block itself does not enforce it
// timing
//   s_axis_tready is high only while the sequencer is idle; one item at a time
//   registry search: one entry per cycle through the registry memory read port
//   batch flush: per record a batch memory read (S_FRD), then an output load
//     (S_FEM) that waits while the output register is stalled
// reset and stall
//   reset clears registry and batch fill counts, elapsed ticks and the
//     output valid flag, and loads the register reset values
//   a stalled receiver holds the output register; the sequencer waits
// ----------------------------------------------------------------------------
module sensor_gateway_register_and_batch
    import sgrb_pkg::*;
#(
    parameter int MAX_ENTRIES = 50,
    parameter int BATCH_DEPTH = 35
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sender_addr[47:0], pkt_type[55:48], frame_len[63:56],
    // weight_bits[95:64], batt_mv[111:96]
    input  logic [111:0] s_axis_tdata,
    // kind[0]
    input  logic [0:0]   s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dest_addr[47:0], ack_ivl[63:48], scale_index[69:64],
    // record_weight[101:70], record_battery[117:102], batch_count[123:118],
    // zero fill[127:124]
    output logic [127:0] m_axis_tdata,
    // result_kind[1:0], end_of_batch[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata
);

    // counter and index widths
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int BW  = $clog2(BATCH_DEPTH + 1);
    localparam int BIW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_FRD    = 3'd3;
    localparam logic [2:0] S_FEM    = 3'd4;
    localparam logic [2:0] S_REPLY  = 3'd5;

    t_frame_data in_data;
    assign in_data = t_frame_data'(s_axis_tdata);

    // configuration
    logic [15:0] r_default_ivl;
    logic [15:0] r_flush_period;

    // control state
    logic [2:0]    r_state;
    logic [EW-1:0] r_entry_count;
    logic [BW-1:0] r_fill;
    logic [15:0]   r_elapsed;
    logic [EW-1:0] r_idx;       // next registry entry to read
    logic          r_cmp_v;     // registry read data is valid to compare
    logic [BW-1:0] r_bj;        // record being flushed
    logic          r_append;    // flush is the early flush before an append
    logic          r_is_data;
    logic          r_out_valid;

    // item context
    logic [47:0]    r_addr;
    logic [31:0]    r_weight;
    logic [15:0]    r_batt;
    logic [1:0]     r_rk;
    logic [15:0]    r_ack_ivl;
    logic [EIW-1:0] r_cmp_idx;
    logic [EIW-1:0] r_hit_idx;

    // registry memory
    logic [47:0]    r_addr_mem [MAX_ENTRIES];
    logic [15:0]    r_ivl_mem  [MAX_ENTRIES];
    logic [47:0]    r_rd_addr;
    logic [15:0]    r_rd_ivl;

    // batch memory
    logic [EIW-1:0] r_bidx_mem [BATCH_DEPTH];
    logic [31:0]    r_bw_mem   [BATCH_DEPTH];
    logic [15:0]    r_bb_mem   [BATCH_DEPTH];
    logic [EIW-1:0] r_rd_bidx;
    logic [31:0]    r_rd_bw;
    logic [15:0]    r_rd_bb;

    // output register
    t_result_data r_out_data;
    t_result_user r_out_user;
    logic         r_out_last;

    logic         in_accept;
    logic         slot_free;
    logic         hit;
    logic         more;
    logic         reg_rd_en;
    logic         reg_we;
    logic         bat_rd_en;
    logic         bat_we;
    logic         rec_final;
    logic [15:0]  n_elapsed;
    logic         out_load;
    t_result_data n_out_data;
    t_result_user n_out_user;
    logic         n_out_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 128'(r_out_data);
    assign m_axis_tuser  = 3'(r_out_user);
    assign m_axis_tlast  = r_out_last;

    // search compare against the entry read in the previous cycle
    assign hit  = (r_state == S_SEARCH) && r_cmp_v && (r_rd_addr == r_addr);
    assign more = (r_idx < r_entry_count);

    assign reg_rd_en = (r_state == S_SEARCH) && !hit && more;
    assign reg_we    = (r_state == S_SEARCH) && !hit && !more && !r_is_data
                       && (r_entry_count < EW'(MAX_ENTRIES));
    assign bat_rd_en = (r_state == S_FRD);
    assign bat_we    = (r_state == S_APPEND);
    assign rec_final = ((r_bj + BW'(1)) == r_fill);

    assign n_elapsed = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 16'd1;

    // result assembly
    always_comb begin
        out_load   = 1'b0;
        n_out_data = '0;
        n_out_user = '0;
        n_out_last = 1'b0;
        if (r_state == S_REPLY) begin
            out_load              = slot_free;
            n_out_data.dest_addr  = r_addr;
            n_out_data.ack_ivl    = r_ack_ivl;
            n_out_user.result_kind = r_rk;
            n_out_last            = 1'b1;
        end else if (r_state == S_FEM) begin
            out_load                  = slot_free;
            n_out_data.scale_index    = 6'(r_rd_bidx);
            n_out_data.record_weight  = r_rd_bw;
            n_out_data.record_battery = r_rd_bb;
            n_out_data.batch_count    = 6'(r_fill);
            n_out_user.result_kind    = RK_RECORD;
            n_out_user.end_of_batch   = rec_final;
            // an early flush is followed by the ack of the appended reading
            n_out_last                = rec_final && !r_append;
        end
    end

    // registry memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_addr_mem[r_entry_count[EIW-1:0]] <= r_addr;
            r_ivl_mem[r_entry_count[EIW-1:0]]  <= r_default_ivl;
        end
        if (reg_rd_en) begin
            r_rd_addr <= r_addr_mem[r_idx[EIW-1:0]];
            r_rd_ivl  <= r_ivl_mem[r_idx[EIW-1:0]];
        end
    end

    // batch memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (bat_we) begin
            r_bidx_mem[r_fill[BIW-1:0]] <= r_hit_idx;
            r_bw_mem[r_fill[BIW-1:0]]   <= r_weight;
            r_bb_mem[r_fill[BIW-1:0]]   <= r_batt;
        end
        if (bat_rd_en) begin
            r_rd_bidx <= r_bidx_mem[r_bj[BIW-1:0]];
            r_rd_bw   <= r_bw_mem[r_bj[BIW-1:0]];
            r_rd_bb   <= r_bb_mem[r_bj[BIW-1:0]];
        end
    end

    // output payload and item context, no reset
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
            r_out_last <= n_out_last;
        end
        if (in_accept) begin
            r_addr   <= in_data.sender_addr;
            r_weight <= in_data.weight_bits;
            r_batt   <= in_data.batt_mv;
            r_rk     <= (in_data.pkt_type == FT_DISCOVER) ? RK_OFFER : RK_ACK;
            r_is_data <= (in_data.pkt_type == FT_DATA);
        end
        if (in_accept) begin
            r_ack_ivl <= '0;
        end else if (hit) begin
            r_ack_ivl <= r_rd_ivl;
        end else if (reg_we) begin
            r_ack_ivl <= r_default_ivl;
        end
        if (reg_rd_en) begin
            r_cmp_idx <= r_idx[EIW-1:0];
        end
        if (hit) begin
            r_hit_idx <= r_cmp_idx;
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_default_ivl  <= DEFAULT_IVL_RST;
            r_flush_period <= FLUSH_PERIOD_RST;
            r_entry_count  <= '0;
            r_fill         <= '0;
            r_elapsed      <= '0;
            r_idx          <= '0;
            r_cmp_v        <= 1'b0;
            r_bj           <= '0;
            r_append       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DEFAULT_IVL:  r_default_ivl  <= i_cfg_wdata;
                    REG_FLUSH_PERIOD: r_flush_period <= i_cfg_wdata;
                    default:          r_default_ivl  <= r_default_ivl;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_idx    <= '0;
                        r_cmp_v  <= 1'b0;
                        r_bj     <= '0;
                        r_append <= 1'b0;
                        if (s_axis_tuser[0] == KIND_TICK) begin
                            r_elapsed <= n_elapsed;
                            if (n_elapsed >= r_flush_period && r_fill != '0) begin
                                r_state <= S_FRD;
                            end
                        end else if (in_data.frame_len != 8'd0) begin
                            if (in_data.pkt_type == FT_DISCOVER) begin
                                r_state <= S_REPLY;
                            end else if (in_data.pkt_type == FT_REGISTER) begin
                                r_state <= S_SEARCH;
                            end else if (in_data.pkt_type == FT_DATA
                                         && in_data.frame_len >= DATA_MIN_LEN) begin
                                r_state <= S_SEARCH;
                            end
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        if (!r_is_data) begin
                            r_state <= S_REPLY;
                        end else if (r_fill >= BW'(BATCH_DEPTH)) begin
                            // full batch goes out before the append
                            r_append <= 1'b1;
                            r_bj     <= '0;
                            r_state  <= S_FRD;
                        end else begin
                            r_state <= S_APPEND;
                        end
                    end else if (more) begin
                        r_cmp_v <= 1'b1;
                        r_idx   <= r_idx + EW'(1);
                    end else if (reg_we) begin
                        r_entry_count <= r_entry_count + EW'(1);
                        r_state       <= S_REPLY;
                    end else begin
                        // unknown data sender or full registry
                        r_state <= S_IDLE;
                    end
                end
                S_APPEND: begin
                    r_fill  <= r_fill + BW'(1);
                    r_state <= S_REPLY;
                end
                S_FRD: begin
                    r_state <= S_FEM;
                end
                S_FEM: begin
                    if (slot_free) begin
                        if (rec_final) begin
                            r_fill    <= '0;
                            r_elapsed <= '0;
                            r_state   <= r_append ? S_APPEND : S_IDLE;
                        end else begin
                            r_bj    <= r_bj + BW'(1);
                            r_state <= S_FRD;
                        end
                    end
                end
                S_REPLY: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // registry never grows past its capacity
    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= EW'(MAX_ENTRIES))
        else $error("registry count beyond capacity");

    // batch never holds more than its depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= BW'(BATCH_DEPTH))
        else $error("batch fill beyond depth");

    // the final record of a flush empties the batch
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEM && slot_free && rec_final) |=> (r_fill == '0
            || r_state == S_REPLY))
        else $error("batch not emptied after flush");

    // end of batch only ever marks a record
    a_eob_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == RK_RECORD))
        else $error("end of batch on a non-record item");

endmodule
